// File: src/pqd_pkg.sv
package pqd_pkg;

  localparam int FRAC_BITS = 14;
  localparam int OW = 16;

  // radicand and root of the square-root section
  localparam int RW = 60;
  localparam int SQ_N = RW / 2;
  localparam int RTW = RW / 2;

  // divider section
  localparam int DW = 30;
  localparam int DVW = DW + 1;
  localparam int QB = FRAC_BITS + 2;
  localparam int NW = FRAC_BITS + 31;

  localparam int LANES = 4;
  localparam int LN_W = 0;
  localparam int LN_X = 1;
  localparam int LN_Y = 2;
  localparam int LN_Z = 3;

  localparam logic [11:0] BIAS_XY = 12'd1023;
  localparam logic [10:0] BIAS_Z = 11'd511;
  localparam logic [17:0] K_Z = 18'd261121;
  localparam logic [19:0] K_XY = 20'd1046529;
  localparam logic [40:0] D_FULL = 41'(K_XY) * 41'(K_Z);
  localparam logic [DW-1:0] DEN_W = DW'(1023 * 511 * 1024);
  localparam logic [DW-1:0] DEN_XY = DW'(1023);
  localparam logic [DW-1:0] DEN_Z = DW'(511);

  typedef struct packed {
    logic [31:0] tm;
    logic last;
    logic norm;
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic signed [9:0] cz;
  } side_t;

  typedef struct packed {
    logic [RW-1:0] v;
    logic [RW-1:0] r;
  } sq_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic qb;
  } dstep_t;

  function automatic sq_t sqrt_step(input sq_t s, input int k);
    sq_t o;
    logic [RW-1:0] b;
    logic [RW:0] t;
    b = RW'(1) << (RW - 2 - 2 * k);
    t = {1'b0, s.r} + {1'b0, b};
    if ({1'b0, s.v} >= t) begin
      o.v = s.v - t[RW-1:0];
      o.r = (s.r >> 1) + b;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic dstep_t div_step(input logic [NW-1:0] rem, input logic [DVW-1:0] dv,
                                      input int k);
    dstep_t o;
    logic [NW+1:0] sh;
    sh = (NW + 2)'(dv) << k;
    if ({2'b00, rem} >= sh) begin
      o.rem = NW'({2'b00, rem} - sh);
      o.qb = 1'b1;
    end else begin
      o.rem = rem;
      o.qb = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [OW-1:0] sat16(input logic [QB-1:0] q, input logic neg);
    logic [63:0] qe;
    logic [OW-1:0] o;
    qe = 64'(q);
    if (neg) begin
      if (qe > 64'd32768) o = 16'h8000;
      else o = 16'(64'd0 - qe);
    end else begin
      if (qe > 64'd32767) o = 16'h7fff;
      else o = qe[OW-1:0];
    end
    return o;
  endfunction

endpackage

// File: src/pqd_in_if.sv
interface pqd_in_if;
  logic valid;
  logic ready;
  logic [31:0] packed_word;
  logic [31:0] key_time;
  logic last_in;

  modport source(output valid, output packed_word, output key_time, output last_in,
                 input ready);
  modport sink(input valid, input packed_word, input key_time, input last_in,
               output ready);
endinterface

// File: src/pqd_out_if.sv
interface pqd_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic [31:0] time_out;
  logic last_out;

  modport source(output valid, output quat_w, output quat_x, output quat_y,
                 output quat_z, output time_out, output last_out, input ready);
  modport sink(input valid, input quat_w, input quat_x, input quat_y, input quat_z,
               input time_out, input last_out, output ready);
endinterface

// File: src/packed_quaternion_decoder_top.sv
// Packed quaternion decoder.
// key_in takes one word per cycle while ready is high: a 32-bit packed
// rotation (11/11/10 bit biased fields x, y, z), its time word and a
// last-row mark. quat_out gives one word per input word: w, x, y, z as
// signed fixed point with FRAC_BITS fraction bits (rounded to nearest),
// plus the copied time and last mark. Unit vectors that land on or outside
// the unit sphere are renormalized and get w = 0; otherwise
// w = -sqrt(1 - x^2 - y^2 - z^2). The pipeline has four front stages
// (unpack, square, scale, radicand), one stage per root bit of the 60-bit
// square root, one operand stage, one stage per quotient bit of the four
// divider lanes and one output register. Throughput is one word per cycle
// while the receiver keeps ready high. Every stage carries its own valid
// bit and moves when the stage after it is empty or moving, so bubbles
// collapse and a stalled receiver freezes only the stages that are full;
// nothing is dropped or repeated. Synchronous reset clears the valid bits
// only; the datapath holds no state between words.
module packed_quaternion_decoder_top (
  input  logic clk,
  input  logic rst,
  pqd_in_if.sink key_in,
  pqd_out_if.source quat_out
);
  import pqd_pkg::*;

  localparam int ST_UNP = 0;
  localparam int ST_SQR = 1;
  localparam int ST_MUL = 2;
  localparam int ST_RAD = 3;
  localparam int ST_SQ0 = 4;
  localparam int ST_PRE = ST_SQ0 + SQ_N;
  localparam int ST_DV0 = ST_PRE + 1;
  localparam int ST_OUT = ST_DV0 + QB;
  localparam int NST = ST_OUT + 1;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  side_t side [NST];

  // front stage payload
  logic [20:0] sq_x;
  logic [20:0] sq_y;
  logic [18:0] sq_z;
  logic [39:0] p_xy;
  logic [38:0] p_z;

  // square root stages: index 0 is the radicand stage
  sq_t sq [SQ_N+1];

  // divider lanes: index 0 is the operand stage
  logic [NW-1:0] dv_rem [QB+1][LANES];
  logic [DVW-1:0] dv_d [QB+1][LANES];
  logic [QB-1:0] dv_q [QB+1][LANES];

  logic [OW-1:0] o_q [LANES];

  // unpack
  logic [11:0] dx, dy;
  logic [10:0] dz;
  side_t side_in;

  always_comb begin
    dx = BIAS_XY - {1'b0, key_in.packed_word[10:0]};
    dy = BIAS_XY - {1'b0, key_in.packed_word[21:11]};
    dz = BIAS_Z - {1'b0, key_in.packed_word[31:22]};
    side_in.tm = key_in.key_time;
    side_in.last = key_in.last_in;
    side_in.norm = 1'b0;
    side_in.cx = dx[10:0];
    side_in.cy = dy[10:0];
    side_in.cz = dz[9:0];
  end

  // squares
  logic signed [21:0] px, py;
  logic signed [19:0] pz;
  always_comb begin
    px = side[ST_UNP].cx * side[ST_UNP].cx;
    py = side[ST_UNP].cy * side[ST_UNP].cy;
    pz = side[ST_UNP].cz * side[ST_UNP].cz;
  end

  // sum of squares against one, then the radicand of the chosen branch
  logic [40:0] s_sum;
  logic [40:0] s_rest;
  logic norm_c;
  always_comb begin
    s_sum = 41'(p_xy) + 41'(p_z);
    s_rest = D_FULL - s_sum;
    norm_c = s_sum >= D_FULL;
  end

  // radicand stage side data picks up the branch choice
  side_t side_rad;
  always_comb begin
    side_rad = side[ST_RAD-1];
    side_rad.norm = norm_c;
  end

  // divider operands
  logic [10:0] ax, ay;
  logic [9:0] az;
  logic [NW-1:0] num [LANES];
  logic [DW-1:0] den [LANES];
  logic [RTW-1:0] root;
  always_comb begin
    ax = side[ST_PRE-1].cx[10] ? 11'(-side[ST_PRE-1].cx) : 11'(side[ST_PRE-1].cx);
    ay = side[ST_PRE-1].cy[10] ? 11'(-side[ST_PRE-1].cy) : 11'(side[ST_PRE-1].cy);
    az = side[ST_PRE-1].cz[9] ? 10'(-side[ST_PRE-1].cz) : 10'(side[ST_PRE-1].cz);
    root = sq[SQ_N].r[RTW-1:0];
    if (side[ST_PRE-1].norm) begin
      num[LN_W] = '0;
      den[LN_W] = DW'(1);
      num[LN_X] = (NW'(ax) * NW'(511)) << (FRAC_BITS + 10);
      num[LN_Y] = (NW'(ay) * NW'(511)) << (FRAC_BITS + 10);
      num[LN_Z] = (NW'(az) * NW'(1023)) << (FRAC_BITS + 10);
      den[LN_X] = root;
      den[LN_Y] = root;
      den[LN_Z] = root;
    end else begin
      num[LN_W] = NW'(root) << FRAC_BITS;
      den[LN_W] = DEN_W;
      num[LN_X] = NW'(ax) << FRAC_BITS;
      num[LN_Y] = NW'(ay) << FRAC_BITS;
      num[LN_Z] = NW'(az) << FRAC_BITS;
      den[LN_X] = DEN_XY;
      den[LN_Y] = DEN_XY;
      den[LN_Z] = DEN_Z;
    end
  end

  // move a stage when it is empty or its successor moves
  always_comb begin
    en[NST-1] = !vld[NST-1] || quat_out.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign key_in.ready = en[ST_UNP];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= key_in.valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dstep_t ds;
    if (en[ST_UNP]) side[ST_UNP] <= side_in;
    for (int i = 1; i < NST; i++) begin
      if (en[i]) side[i] <= (i == ST_RAD) ? side_rad : side[i-1];
    end

    if (en[ST_SQR]) begin
      sq_x <= px[20:0];
      sq_y <= py[20:0];
      sq_z <= pz[18:0];
    end
    if (en[ST_MUL]) begin
      p_xy <= 40'(22'(sq_x) + 22'(sq_y)) * 40'(K_Z);
      p_z <= 39'(sq_z) * 39'(K_XY);
    end
    if (en[ST_RAD]) begin
      sq[0].v <= norm_c ? (RW'(s_sum[39:0]) << 20) : (RW'(s_rest[39:0]) << 20);
      sq[0].r <= '0;
    end
    for (int i = 0; i < SQ_N; i++) begin
      if (en[ST_SQ0+i]) sq[i+1] <= sqrt_step(sq[i], i);
    end

    if (en[ST_PRE]) begin
      for (int l = 0; l < LANES; l++) begin
        dv_rem[0][l] <= NW'({num[l], 1'b0}) + NW'(den[l]);
        dv_d[0][l] <= {den[l], 1'b0};
        dv_q[0][l] <= '0;
      end
    end
    for (int j = 0; j < QB; j++) begin
      if (en[ST_DV0+j]) begin
        for (int l = 0; l < LANES; l++) begin
          ds = div_step(dv_rem[j][l], dv_d[j][l], QB - 1 - j);
          dv_rem[j+1][l] <= ds.rem;
          dv_d[j+1][l] <= dv_d[j][l];
          dv_q[j+1][l] <= dv_q[j][l] | (QB'(ds.qb) << (QB - 1 - j));
        end
      end
    end

    if (en[ST_OUT]) begin
      o_q[LN_W] <= sat16(dv_q[QB][LN_W], !side[ST_OUT-1].norm);
      o_q[LN_X] <= sat16(dv_q[QB][LN_X], side[ST_OUT-1].cx[10]);
      o_q[LN_Y] <= sat16(dv_q[QB][LN_Y], side[ST_OUT-1].cy[10]);
      o_q[LN_Z] <= sat16(dv_q[QB][LN_Z], side[ST_OUT-1].cz[9]);
    end
  end

  assign quat_out.valid = vld[ST_OUT];
  assign quat_out.quat_w = o_q[LN_W];
  assign quat_out.quat_x = o_q[LN_X];
  assign quat_out.quat_y = o_q[LN_Y];
  assign quat_out.quat_z = o_q[LN_Z];
  assign quat_out.time_out = side[ST_OUT].tm;
  assign quat_out.last_out = side[ST_OUT].last;

  // an accepted word always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    key_in.valid && key_in.ready |=> vld[ST_UNP])
    else $error("accepted word missing from first stage");

  // floor square root leaves a remainder no larger than twice the root
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    vld[ST_PRE-1] |-> ({1'b0, sq[SQ_N].v} <= ({1'b0, sq[SQ_N].r} << 1)))
    else $error("square root remainder out of range");

  // renormalized keys carry a zero w
  a_norm_w_zero: assert property (@(posedge clk) disable iff (rst)
    vld[ST_OUT] && side[ST_OUT].norm |-> quat_out.quat_w == 16'sd0)
    else $error("nonzero w on renormalized key");

endmodule

// File: verif/tb_packed_quaternion_decoder_top.sv
module tb_packed_quaternion_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pqd_pkg::*;

  // Pipeline depth of the block; used for the final drain.
  localparam int LATENCY = 36 + QB;

  typedef struct {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [31:0] tm;
    logic        last;
  } quat_t;

  logic clk;
  logic rst;

  pqd_in_if  key_in();
  pqd_out_if quat_out();

  packed_quaternion_decoder_top dut (
    .clk(clk),
    .rst(rst),
    .key_in(key_in.sink),
    .quat_out(quat_out.source)
  );

  // Decoded words still owed by the block, oldest first.
  quat_t pending_quats[$];
  int    error_count;
  int    tx_idle_pct;
  int    rx_idle_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Integer square root, floor.
  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Round num/den to nearest (ties away from zero), then clamp to 16 bits.
  function automatic logic [15:0] round_clamp(input longint num, input longint unsigned den);
    logic            neg;
    longint unsigned mag;
    longint unsigned q;
    neg = num < 0;
    mag = neg ? longint'(0) - num : num;
    if (den == 0) return 16'h0000;
    q = (2 * mag + den) / (2 * den);
    if (neg) begin
      if (q > 32768) return 16'h8000;
      return 16'(longint'(0) - longint'(q));
    end
    if (q > 32767) return 16'h7fff;
    return q[15:0];
  endfunction

  // Unpack the 11/11/10 key and build the quaternion, bit exact.
  function automatic quat_t decode_key(input logic [31:0] word, input logic [31:0] tm,
                                       input logic last);
    quat_t           q;
    longint          cx;
    longint          cy;
    longint          cz;
    longint          one;
    longint unsigned sq_sum;
    longint unsigned full;
    longint unsigned root;
    cx = 1023 - longint'(word[10:0]);
    cy = 1023 - longint'(word[21:11]);
    cz = 511 - longint'(word[31:22]);
    one = longint'(1) << FRAC_BITS;
    full = 64'd1046529 * 64'd261121;
    sq_sum = longint'(cx * cx + cy * cy) * 64'd261121 + longint'(cz * cz) * 64'd1046529;
    if (sq_sum >= full) begin
      root = int_root(sq_sum << 20);
      q.w = 16'h0000;
      q.x = round_clamp(cx * 511 * (one << 10), root);
      q.y = round_clamp(cy * 511 * (one << 10), root);
      q.z = round_clamp(cz * 1023 * (one << 10), root);
    end else begin
      root = int_root((full - sq_sum) << 20);
      q.w = round_clamp(-longint'(root << FRAC_BITS), 64'd1023 * 64'd511 * 64'd1024);
      q.x = round_clamp(cx * one, 1023);
      q.y = round_clamp(cy * one, 1023);
      q.z = round_clamp(cz * one, 511);
    end
    q.tm = tm;
    q.last = last;
    return q;
  endfunction

  // Receiver back-pressure: drop ready in rx_idle_pct cycles of a hundred.
  always @(posedge clk) begin
    if (rst) quat_out.ready <= 1'b0;
    else quat_out.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare every accepted output word with the oldest prediction.
  always @(posedge clk) begin
    quat_t e;
    if (!rst && quat_out.valid && quat_out.ready) begin
      if (pending_quats.size() == 0) begin
        $display("%0t: unexpected word w=%h x=%h y=%h z=%h t=%h l=%b", $time,
                 quat_out.quat_w, quat_out.quat_x, quat_out.quat_y, quat_out.quat_z,
                 quat_out.time_out, quat_out.last_out);
        error_count++;
      end else begin
        e = pending_quats.pop_front();
        if (quat_out.quat_w !== e.w || quat_out.quat_x !== e.x ||
            quat_out.quat_y !== e.y || quat_out.quat_z !== e.z ||
            quat_out.time_out !== e.tm || quat_out.last_out !== e.last) begin
          $display("%0t: mismatch expected w=%h x=%h y=%h z=%h t=%h l=%b", $time,
                   e.w, e.x, e.y, e.z, e.tm, e.last);
          $display("%0t:          actual   w=%h x=%h y=%h z=%h t=%h l=%b", $time,
                   quat_out.quat_w, quat_out.quat_x, quat_out.quat_y, quat_out.quat_z,
                   quat_out.time_out, quat_out.last_out);
          error_count++;
        end
      end
    end
  end

  // Offer one key, idling first at random; hold until the block takes it.
  // valid stays high on return so back-to-back keys need no re-raise.
  task automatic send_key(input logic [31:0] word, input logic [31:0] tm, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      key_in.valid <= 1'b0;
      @(posedge clk);
    end
    key_in.valid <= 1'b1;
    key_in.packed_word <= word;
    key_in.key_time <= tm;
    key_in.last_in <= last;
    do @(posedge clk); while (!key_in.ready);
    pending_quats.insert(pending_quats.size(), decode_key(word, tm, last));
  endtask

  task automatic pack_and_send(input int a, input int b, input int c);
    send_key({c[9:0], b[10:0], a[10:0]}, $urandom, 1'($urandom_range(1)));
  endtask

  // Stop offering and let every owed word come out.
  task automatic drain_block();
    key_in.valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Field extremes: each raw field at zero, bias and full scale.
  task automatic test_field_extremes();
    int xy_vals[3] = '{0, 1023, 2047};
    int z_vals[3] = '{0, 511, 1023};
    foreach (xy_vals[i]) begin
      pack_and_send(xy_vals[i], 1023, 511);
      pack_and_send(1023, xy_vals[i], 511);
      pack_and_send(1023, 1023, z_vals[i]);
    end
    pack_and_send(2047, 2047, 1023);
    pack_and_send(0, 0, 0);
    send_key(32'h0000_0000, 32'hffff_ffff, 1'b1);
    send_key(32'hffff_ffff, 32'h0000_0000, 1'b0);
  endtask

  // Sum of squares right at and just under one.
  task automatic test_sphere_boundary();
    pack_and_send(0, 1023, 511);
    pack_and_send(1, 1023, 511);
    pack_and_send(1023, 0, 511);
    pack_and_send(1023, 1023, 0);
    pack_and_send(1023, 1023, 1);
    pack_and_send(300, 1023, 511);
    pack_and_send(300, 300, 511);
  endtask

  // Keys in the direct branch with the sum just below one.
  task automatic test_zero_w();
    pack_and_send(2, 1023, 511);
    pack_and_send(1, 1022, 511);
    pack_and_send(1023, 1023, 2);
  endtask

  // Random keys in three idling phases; half with y and z held near zero.
  task automatic test_random_keys();
    int tx_pct[3] = '{21, 68, 0};
    int rx_pct[3] = '{68, 21, 0};
    int a;
    int b;
    int c;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      for (int n = 0; n < 660; n++) begin
        if ($urandom_range(1)) begin
          send_key($urandom, $urandom, 1'($urandom_range(1)));
        end else begin
          a = $urandom_range(1023) + $urandom_range(20) - 10;
          a = (a < 0) ? 0 : a;
          b = 1023 - $urandom_range(40) + $urandom_range(40);
          c = 511 - $urandom_range(20) + $urandom_range(20);
          pack_and_send(a, b, c);
        end
        // hold the sender once until the pipeline empties
        if (ph == 1 && n == 300) begin
          key_in.valid <= 1'b0;
          while (pending_quats.size() != 0) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    error_count = 0;
    tx_idle_pct = 21;
    rx_idle_pct = 68;
    rst = 1'b1;
    key_in.valid = 1'b0;
    key_in.packed_word = '0;
    key_in.key_time = '0;
    key_in.last_in = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_sphere_boundary();
    test_zero_w();
    test_random_keys();
    drain_block();

    if (error_count == 0) $display("packed_quaternion_decoder_top regression: pass");
    else $display("packed_quaternion_decoder_top regression: fail");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("packed_quaternion_decoder_top regression: fail");
    $finish;
  end

endmodule
